### hdl/cact_pkg.sv
// ----------------------------------------------------------------------------
// cact_pkg: shared constants for the call arc counter table
// Default sizes, port field widths and result status codes.
// ----------------------------------------------------------------------------
package cact_pkg;

  localparam int BUCKETS_DEF     = 4096;
  localparam int ARC_ENTRIES_DEF = 4096;
  localparam int HASH_DIV_DEF    = 4;

  localparam int ADDR_W     = 32;
  localparam int IN_DATA_W  = 64;
  localparam int OUT_DATA_W = 48;
  localparam int STATUS_W   = 3;
  localparam int OUT_SLOT_W = 12;
  localparam int TOTAL_W    = 32;
  localparam int LIMIT_W    = 13;

  localparam logic [LIMIT_W-1:0] LIMIT_RST = 13'd4096;

  typedef enum logic [STATUS_W-1:0] {
    STS_HEAD_HIT = 3'd0,
    STS_MOVED    = 3'd1,
    STS_NEW      = 3'd2,
    STS_FULL     = 3'd3,
    STS_RANGE    = 3'd4
  } arc_status_t;

endpackage

### hdl/cact_bucket_hash.sv
// ----------------------------------------------------------------------------
// cact_bucket_hash: caller address to bucket index
// Divides the caller address by twice the hash factor with a reciprocal
// multiply and flags addresses whose bucket lies beyond the table.
// ----------------------------------------------------------------------------
module cact_bucket_hash
  import cact_pkg::*;
#(
  parameter int BUCKETS  = BUCKETS_DEF,
  parameter int HASH_DIV = HASH_DIV_DEF
) (
  input  logic                       clk,
  input  logic                       load,
  input  logic [ADDR_W-1:0]          caller,
  output logic [$clog2(BUCKETS)-1:0] bucket,
  output logic                       out_of_range
);

  localparam int BKT_W  = $clog2(BUCKETS);
  localparam int GRAIN  = HASH_DIV * 2;
  localparam int SPAN   = BUCKETS * GRAIN;
  localparam int DIV_W  = $clog2(SPAN);
  localparam int SH     = $clog2(GRAIN);
  localparam longint unsigned RECIP = ((64'd1 << (DIV_W + SH)) + GRAIN - 1) / GRAIN;
  localparam int RCP_W  = $clog2(RECIP + 1);
  localparam int PROD_W = DIV_W + RCP_W;
  localparam logic [ADDR_W-1:0] SPAN_V = ADDR_W'(SPAN);

  logic [PROD_W-1:0] prod_r, prod_nxt;
  logic              oor_r, oor_nxt;
  logic [PROD_W-1:0] quot;

  // exact for every dividend below 2**DIV_W, which covers all in-range callers
  always_comb begin
    prod_nxt = prod_r;
    oor_nxt  = oor_r;
    if (load) begin
      prod_nxt = PROD_W'(caller[DIV_W-1:0]) * PROD_W'(RECIP);
      oor_nxt  = caller >= SPAN_V;
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
    oor_r  <= oor_nxt;
  end

  assign quot         = prod_r >> (DIV_W + SH);
  assign bucket       = quot[BKT_W-1:0];
  assign out_of_range = oor_r;

endmodule

### hdl/call_arc_counter_table.sv
// ----------------------------------------------------------------------------
// call_arc_counter_table: caller-to-callee call arc counter
// Hashes the caller into a bucket, walks the bucket's arc chain and counts,
// moves to front or allocates the arc; one status beat per input beat.
// ----------------------------------------------------------------------------
// One call is handled at a time; the cost is set by the arc chain walk
// through the arc memory (one read and one write port), one link per cycle.
// A call ends early when its bucket is out of range or empty; else the walk
// runs until the callee is hit or the chain ends. After reset a clearing
// pass writes every bucket head to empty with in_tready low; cfg writes are
// taken throughout. A finished result waits in the output register while the
// next call is already accepted.
module call_arc_counter_table
  import cact_pkg::*;
#(
  parameter int BUCKETS     = BUCKETS_DEF,
  parameter int ARC_ENTRIES = ARC_ENTRIES_DEF,
  parameter int HASH_DIV    = HASH_DIV_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,   // caller_addr[31:0], callee_addr[63:32]
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,  // status[2:0], arc_slot[14:3],
                                            // arc_total[46:15], zero pad[47]
  input  logic                  cfg_we,
  input  logic [LIMIT_W-1:0]    cfg_wdata
);

  localparam int BKT_W  = $clog2(BUCKETS);
  localparam int SLOT_W = $clog2(ARC_ENTRIES);
  localparam int ARC_W  = 2 * TOTAL_W + SLOT_W;
  localparam int LIM_W  = (SLOT_W + 1 > LIMIT_W) ? SLOT_W + 1 : LIMIT_W;
  localparam logic [BKT_W-1:0] LAST_BKT = BKT_W'(BUCKETS - 1);

  typedef enum logic [6:0] {
    S_CLEAR = 7'b0000001,
    S_IDLE  = 7'b0000010,
    S_HEAD  = 7'b0000100,
    S_HDATA = 7'b0001000,
    S_WALK  = 7'b0010000,
    S_MOVE  = 7'b0100000,
    S_HOLD  = 7'b1000000
  } state_t;

  // arc word: {target, tally, next}
  function automatic logic [ARC_W-1:0] pack_arc(input logic [TOTAL_W-1:0] tgt,
                                                input logic [TOTAL_W-1:0] cnt,
                                                input logic [SLOT_W-1:0]  nxt);
    return {tgt, cnt, nxt};
  endfunction

  logic [SLOT_W-1:0] head_mem [BUCKETS];
  logic [ARC_W-1:0]  arc_mem  [ARC_ENTRIES];

  logic              head_we;
  logic [BKT_W-1:0]  head_waddr, head_raddr;
  logic [SLOT_W-1:0] head_wdata, head_q;
  logic              arc_we;
  logic [SLOT_W-1:0] arc_waddr, arc_raddr;
  logic [ARC_W-1:0]  arc_wdata, arc_q;

  state_t             state_r, state_nxt;
  logic [BKT_W-1:0]   clr_r, clr_nxt;
  logic [LIMIT_W-1:0] limit_r, limit_nxt;
  logic [SLOT_W-1:0]  alloc_top_r, alloc_top_nxt;
  logic [TOTAL_W-1:0] callee_r, callee_nxt;
  logic [SLOT_W-1:0]  head_r, head_nxt;
  logic [SLOT_W-1:0]  cur_r, cur_nxt;
  logic [SLOT_W-1:0]  prev_r, prev_nxt;
  logic [ARC_W-1:0]   prev_word_r, prev_word_nxt;
  logic [ARC_W-1:0]   cur_word_r, cur_word_nxt;
  logic               first_r, first_nxt;

  arc_status_t        res_status_r, res_status_nxt;
  logic [SLOT_W-1:0]  res_slot_r, res_slot_nxt;
  logic [TOTAL_W-1:0] res_total_r, res_total_nxt;

  logic               out_valid_r, out_valid_nxt;
  arc_status_t        out_status_r, out_status_nxt;
  logic [SLOT_W-1:0]  out_slot_r, out_slot_nxt;
  logic [TOTAL_W-1:0] out_total_r, out_total_nxt;

  logic              in_accept;
  logic [BKT_W-1:0]  bucket;
  logic              out_of_range;

  cact_bucket_hash #(
    .BUCKETS  (BUCKETS),
    .HASH_DIV (HASH_DIV)
  ) u_hash (
    .clk          (clk),
    .load         (in_accept),
    .caller       (in_tdata[ADDR_W-1:0]),
    .bucket       (bucket),
    .out_of_range (out_of_range)
  );

  assign in_tready = (state_r == S_IDLE);
  assign in_accept = in_tvalid && in_tready;

  // bucket head memory
  always_ff @(posedge clk) begin
    if (head_we) begin
      head_mem[head_waddr] <= head_wdata;
    end
    head_q <= head_mem[head_raddr];
  end

  // arc pool memory
  always_ff @(posedge clk) begin
    if (arc_we) begin
      arc_mem[arc_waddr] <= arc_wdata;
    end
    arc_q <= arc_mem[arc_raddr];
  end

  always_comb begin
    logic [LIM_W-1:0]   lim;
    logic [LIM_W-1:0]   cand;
    logic               full;
    logic               do_alloc;
    logic [SLOT_W-1:0]  hv;
    logic               fin;
    arc_status_t        fin_status;
    logic [SLOT_W-1:0]  fin_slot;
    logic [TOTAL_W-1:0] fin_total;
    logic               out_free;
    logic [TOTAL_W-1:0] w_target;
    logic [TOTAL_W-1:0] w_tally;
    logic [SLOT_W-1:0]  w_next;

    lim = (LIM_W'(limit_r) > LIM_W'(ARC_ENTRIES)) ? LIM_W'(ARC_ENTRIES)
                                                   : LIM_W'(limit_r);
    cand = LIM_W'(alloc_top_r) + LIM_W'(1);
    full = cand >= lim;
    out_free = !out_valid_r || out_tready;

    w_target = arc_q[ARC_W-1 -: TOTAL_W];
    w_tally  = arc_q[SLOT_W +: TOTAL_W];
    w_next   = arc_q[SLOT_W-1:0];

    do_alloc   = 1'b0;
    hv         = head_r;
    fin        = 1'b0;
    fin_status = STS_HEAD_HIT;
    fin_slot   = '0;
    fin_total  = '0;

    state_nxt     = state_r;
    clr_nxt       = clr_r;
    limit_nxt     = cfg_we ? cfg_wdata : limit_r;
    alloc_top_nxt = alloc_top_r;
    callee_nxt    = callee_r;
    head_nxt      = head_r;
    cur_nxt       = cur_r;
    prev_nxt      = prev_r;
    prev_word_nxt = prev_word_r;
    cur_word_nxt  = cur_word_r;
    first_nxt     = first_r;
    res_status_nxt = res_status_r;
    res_slot_nxt   = res_slot_r;
    res_total_nxt  = res_total_r;

    head_we    = 1'b0;
    head_waddr = bucket;
    head_wdata = '0;
    head_raddr = bucket;
    arc_we     = 1'b0;
    arc_waddr  = cur_r;
    arc_wdata  = '0;
    arc_raddr  = '0;

    out_valid_nxt  = out_tready ? 1'b0 : out_valid_r;
    out_status_nxt = out_status_r;
    out_slot_nxt   = out_slot_r;
    out_total_nxt  = out_total_r;

    case (state_r)
      S_CLEAR: begin
        head_we    = 1'b1;
        head_waddr = clr_r;
        clr_nxt    = clr_r + BKT_W'(1);
        if (clr_r == LAST_BKT) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_accept) begin
          callee_nxt = in_tdata[IN_DATA_W-1 -: TOTAL_W];
          state_nxt  = S_HEAD;
        end
      end
      S_HEAD: begin
        if (out_of_range) begin
          fin        = 1'b1;
          fin_status = STS_RANGE;
        end else begin
          state_nxt = S_HDATA;
        end
      end
      S_HDATA: begin
        head_nxt = head_q;
        if (head_q == '0) begin
          do_alloc = 1'b1;
          hv       = head_q;
        end else begin
          arc_raddr = head_q;
          cur_nxt   = head_q;
          first_nxt = 1'b1;
          state_nxt = S_WALK;
        end
      end
      S_WALK: begin
        if (w_target == callee_r) begin
          if (first_r) begin
            arc_we     = 1'b1;
            arc_waddr  = cur_r;
            arc_wdata  = pack_arc(w_target, w_tally + TOTAL_W'(1), w_next);
            fin        = 1'b1;
            fin_status = STS_HEAD_HIT;
            fin_slot   = cur_r;
            fin_total  = w_tally + TOTAL_W'(1);
          end else begin
            // unlink: predecessor skips over the hit entry
            arc_we       = 1'b1;
            arc_waddr    = prev_r;
            arc_wdata    = pack_arc(prev_word_r[ARC_W-1 -: TOTAL_W],
                                    prev_word_r[SLOT_W +: TOTAL_W], w_next);
            cur_word_nxt = arc_q;
            state_nxt    = S_MOVE;
          end
        end else if (w_next == '0) begin
          do_alloc = 1'b1;
          hv       = head_r;
        end else begin
          arc_raddr     = w_next;
          prev_nxt      = cur_r;
          prev_word_nxt = arc_q;
          cur_nxt       = w_next;
          first_nxt     = 1'b0;
        end
      end
      S_MOVE: begin
        arc_we     = 1'b1;
        arc_waddr  = cur_r;
        arc_wdata  = pack_arc(cur_word_r[ARC_W-1 -: TOTAL_W],
                              cur_word_r[SLOT_W +: TOTAL_W] + TOTAL_W'(1), head_r);
        head_we    = 1'b1;
        head_wdata = cur_r;
        fin        = 1'b1;
        fin_status = STS_MOVED;
        fin_slot   = cur_r;
        fin_total  = cur_word_r[SLOT_W +: TOTAL_W] + TOTAL_W'(1);
      end
      S_HOLD: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_slot_nxt   = res_slot_r;
          out_total_nxt  = res_total_r;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (do_alloc) begin
      fin = 1'b1;
      if (full) begin
        fin_status = STS_FULL;
      end else begin
        arc_we        = 1'b1;
        arc_waddr     = cand[SLOT_W-1:0];
        arc_wdata     = pack_arc(callee_r, TOTAL_W'(1), hv);
        head_we       = 1'b1;
        head_wdata    = cand[SLOT_W-1:0];
        alloc_top_nxt = cand[SLOT_W-1:0];
        fin_status    = STS_NEW;
        fin_slot      = cand[SLOT_W-1:0];
        fin_total     = TOTAL_W'(1);
      end
    end

    // hand the result to the output register, or park it until space frees
    if (fin) begin
      if (out_free) begin
        out_valid_nxt  = 1'b1;
        out_status_nxt = fin_status;
        out_slot_nxt   = fin_slot;
        out_total_nxt  = fin_total;
        state_nxt      = S_IDLE;
      end else begin
        res_status_nxt = fin_status;
        res_slot_nxt   = fin_slot;
        res_total_nxt  = fin_total;
        state_nxt      = S_HOLD;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_r       <= '0;
      limit_r     <= LIMIT_RST;
      alloc_top_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      limit_r     <= limit_nxt;
      alloc_top_r <= alloc_top_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    callee_r     <= callee_nxt;
    head_r       <= head_nxt;
    cur_r        <= cur_nxt;
    prev_r       <= prev_nxt;
    prev_word_r  <= prev_word_nxt;
    cur_word_r   <= cur_word_nxt;
    first_r      <= first_nxt;
    res_status_r <= res_status_nxt;
    res_slot_r   <= res_slot_nxt;
    res_total_r  <= res_total_nxt;
    out_status_r <= out_status_nxt;
    out_slot_r   <= out_slot_nxt;
    out_total_r  <= out_total_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, out_total_r, OUT_SLOT_W'(out_slot_r), out_status_r};

endmodule

### tb/call_arc_counter_table_tb.sv
// ----------------------------------------------------------------------------
// call_arc_counter_table_tb: regression bench for the call arc counter table
// Sends caller/callee beats in random bursts against a stalling sink. Every
// result beat is checked field by field against the typed result of its row,
// if any, else a behavioral shadow of the bucket heads, arc chains and allocator.
// Runs a short directed table, then random traffic over several arc limits.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module call_arc_counter_table_tb;
  import cact_pkg::*;

  localparam int NDIR            = 23;
  localparam int NPHASE          = 6;
  localparam int PHASE_CALLS     = 180;
  localparam int NEAR_FULL_PHASE = 2;
  localparam int NHOT_BUCKETS    = 12;
  localparam int NHOT_CALLEES    = 8;
  localparam int SETTLE_CYCLES   = 40;

  // limit per random phase; the near-full entry is replaced at run time
  localparam logic [LIMIT_W-1:0] PHASE_LIMIT [NPHASE] =
    '{13'd4096, 13'd0, 13'd0, 13'd8191, 13'd1, 13'd2500};

  typedef struct packed {
    arc_status_t             status;
    logic [OUT_SLOT_W-1:0]   slot;
    logic [TOTAL_W-1:0]      total;
  } arc_result_t;

  typedef enum logic {ROW_CALL, ROW_LIMIT} row_kind_t;

  typedef struct packed {
    row_kind_t           kind;
    logic [ADDR_W-1:0]   caller;
    logic [ADDR_W-1:0]   callee;
    logic [LIMIT_W-1:0]  limit;
    logic                typed;
    arc_result_t         want;
  } row_t;

  typedef enum logic [1:0] {READY_ALWAYS, READY_RANDOM, READY_SPARSE} ready_mode_t;

  logic                  clk;
  logic                  rst_n      = 1'b0;
  logic                  in_tvalid  = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata   = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  cfg_we     = 1'b0;
  logic [LIMIT_W-1:0]    cfg_wdata  = '0;

  // shadow of the table state
  logic [OUT_SLOT_W-1:0] bucket_first [BUCKETS_DEF];
  logic [ADDR_W-1:0]     slot_callee  [ARC_ENTRIES_DEF];
  logic [TOTAL_W-1:0]    slot_count   [ARC_ENTRIES_DEF];
  logic [OUT_SLOT_W-1:0] slot_link    [ARC_ENTRIES_DEF];
  int                    next_free;
  int                    limit_shadow;

  arc_result_t pending_arcs [$];
  arc_result_t oldest;
  row_t        dir_rows [NDIR];

  int errors       = 0;
  int calls_sent   = 0;
  int limit_writes = 0;
  int burst_left   = 0;
  int status_seen [5];

  ready_mode_t ready_mode = READY_ALWAYS;
  int          ready_left = 0;

  call_arc_counter_table #(
    .BUCKETS    (BUCKETS_DEF),
    .ARC_ENTRIES(ARC_ENTRIES_DEF),
    .HASH_DIV   (HASH_DIV_DEF)
  ) i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),    // caller_addr[31:0], callee_addr[63:32]
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),   // status[2:0], arc_slot[14:3], arc_total[46:15], pad[47]
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #4_000_000;
    $display("call_arc_counter_table regression: fail");
    $finish;
  end

  function automatic arc_result_t allocate_arc(input logic [OUT_SLOT_W-1:0] b,
                                               input logic [ADDR_W-1:0] callee);
    arc_result_t res;
    int          lim;
    int          cand;
    res  = '0;
    lim  = (limit_shadow > ARC_ENTRIES_DEF) ? ARC_ENTRIES_DEF : limit_shadow;
    cand = next_free + 1;
    if (cand >= lim) begin
      res.status = STS_FULL;
      return res;
    end
    next_free         = cand;
    slot_callee[cand] = callee;
    slot_count[cand]  = 32'd1;
    slot_link[cand]   = bucket_first[b];
    bucket_first[b]   = cand[OUT_SLOT_W-1:0];
    res.status = STS_NEW;
    res.slot   = cand[OUT_SLOT_W-1:0];
    res.total  = 32'd1;
    return res;
  endfunction

  function automatic arc_result_t count_arc(input logic [ADDR_W-1:0] caller,
                                            input logic [ADDR_W-1:0] callee);
    arc_result_t           res;
    logic [ADDR_W-1:0]     bidx;
    logic [OUT_SLOT_W-1:0] b, cur, prv, nxt;
    res  = '0;
    bidx = caller / 32'(HASH_DIV_DEF * 2);
    if (bidx >= BUCKETS_DEF) begin
      res.status = STS_RANGE;
      return res;
    end
    b   = bidx[OUT_SLOT_W-1:0];
    cur = bucket_first[b];
    if (cur == 0) return allocate_arc(b, callee);
    if (slot_callee[cur] == callee) begin
      slot_count[cur] = slot_count[cur] + 1;
      res.status = STS_HEAD_HIT;
      res.slot   = cur;
      res.total  = slot_count[cur];
      return res;
    end
    for (int steps = 0; steps < ARC_ENTRIES_DEF; steps++) begin
      nxt = slot_link[cur];
      if (nxt == 0) break;
      prv = cur;
      cur = nxt;
      if (slot_callee[cur] == callee) begin
        // unlink and move to the front of the chain
        slot_count[cur] = slot_count[cur] + 1;
        slot_link[prv]  = slot_link[cur];
        slot_link[cur]  = bucket_first[b];
        bucket_first[b] = cur;
        res.status = STS_MOVED;
        res.slot   = cur;
        res.total  = slot_count[cur];
        return res;
      end
    end
    return allocate_arc(b, callee);
  endfunction

  task automatic send_call(input logic [ADDR_W-1:0] caller, input logic [ADDR_W-1:0] callee,
                           input logic typed, input arc_result_t typed_res);
    arc_result_t pred;
    in_tvalid <= 1'b1;
    in_tdata  <= {callee, caller};
    do @(posedge clk); while (!in_tready);
    pred = count_arc(caller, callee);
    pending_arcs.push_back(typed ? typed_res : pred);
    calls_sent++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
      burst_left = $urandom_range(0, 30);
    end
  endtask

  task automatic release_input();
    if (in_tvalid) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    burst_left = 0;
  endtask

  // write only with the table idle: no beat in flight, every result drained
  task automatic set_arc_limit(input logic [LIMIT_W-1:0] value);
    release_input();
    while (pending_arcs.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we    <= 1'b0;
    limit_shadow = int'(value);
    limit_writes++;
  endtask

  task automatic check_field(input string fname, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      errors++;
      $display("%0t ns: %s mismatch: expected %0d, got %0d", $time, fname, want, got);
    end
  endtask

  // sink stall pattern: switch among always-ready, random and sparse modes
  always @(posedge clk) begin
    if (ready_left == 0) begin
      ready_mode <= ready_mode_t'($urandom_range(0, 2));
      ready_left <= $urandom_range(20, 120);
    end else begin
      ready_left <= ready_left - 1;
    end
    case (ready_mode)
      READY_ALWAYS: out_tready <= 1'b1;
      READY_RANDOM: out_tready <= ($urandom_range(0, 3) != 0);
      default:      out_tready <= (ready_left % 11 == 0);
    endcase
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_arcs.size() == 0) begin
        errors++;
        $display("%0t ns: result beat with nothing expected: %h", $time, out_tdata);
      end else begin
        oldest = pending_arcs.pop_front();
        check_field("status", 32'(oldest.status), 32'(out_tdata[2:0]));
        check_field("arc_slot", 32'(oldest.slot), 32'(out_tdata[14:3]));
        check_field("arc_total", oldest.total, out_tdata[46:15]);
        status_seen[oldest.status]++;
      end
    end
  end

  initial begin
    logic [OUT_SLOT_W-1:0] hot_bucket [NHOT_BUCKETS];
    logic [ADDR_W-1:0]     hot_callee [NHOT_CALLEES];
    logic [ADDR_W-1:0]     caller, callee;
    logic [LIMIT_W-1:0]    lim;
    int                    r;

    for (int i = 0; i < BUCKETS_DEF; i++) bucket_first[i] = '0;
    for (int i = 0; i < ARC_ENTRIES_DEF; i++) begin
      slot_callee[i] = '0;
      slot_count[i]  = '0;
      slot_link[i]   = '0;
    end
    next_free    = 0;
    limit_shadow = int'(LIMIT_RST);
    for (int i = 0; i < 5; i++) status_seen[i] = 0;

    //           kind       caller        callee        limit     typed  status slot total
    dir_rows = '{
      '{ROW_CALL,  32'h0000_0000, 32'h0000_1000, 13'd0,    1'b1, '{STS_NEW,      12'd1, 32'd1}},
      '{ROW_CALL,  32'h0000_0000, 32'h0000_1000, 13'd0,    1'b1, '{STS_HEAD_HIT, 12'd1, 32'd2}},
      '{ROW_CALL,  32'h0000_0007, 32'hFFFF_FFFF, 13'd0,    1'b1, '{STS_NEW,      12'd2, 32'd1}},
      '{ROW_CALL,  32'h0000_0003, 32'h0000_1000, 13'd0,    1'b1, '{STS_MOVED,    12'd1, 32'd3}},
      '{ROW_CALL,  32'h0000_0000, 32'h0000_1000, 13'd0,    1'b1, '{STS_HEAD_HIT, 12'd1, 32'd4}},
      '{ROW_CALL,  32'h0000_7FFF, 32'h0000_0000, 13'd0,    1'b1, '{STS_NEW,      12'd3, 32'd1}},
      '{ROW_CALL,  32'h0000_7FF8, 32'h0000_0000, 13'd0,    1'b1, '{STS_HEAD_HIT, 12'd3, 32'd2}},
      '{ROW_CALL,  32'h0000_8000, 32'h0000_1000, 13'd0,    1'b1, '{STS_RANGE,    12'd0, 32'd0}},
      '{ROW_CALL,  32'hFFFF_FFFF, 32'hFFFF_FFFF, 13'd0,    1'b1, '{STS_RANGE,    12'd0, 32'd0}},
      '{ROW_CALL,  32'h8000_0000, 32'h0000_0000, 13'd0,    1'b1, '{STS_RANGE,    12'd0, 32'd0}},
      '{ROW_CALL,  32'h0000_0008, 32'hFFFF_FFFF, 13'd0,    1'b1, '{STS_NEW,      12'd4, 32'd1}},
      '{ROW_CALL,  32'h0000_0005, 32'h0000_0000, 13'd0,    1'b1, '{STS_NEW,      12'd5, 32'd1}},
      '{ROW_CALL,  32'h0000_0001, 32'hFFFF_FFFF, 13'd0,    1'b0, '{STS_HEAD_HIT, 12'd0, 32'd0}},
      '{ROW_LIMIT, 32'h0000_0000, 32'h0000_0000, 13'd6,    1'b0, '{STS_HEAD_HIT, 12'd0, 32'd0}},
      '{ROW_CALL,  32'h0000_0010, 32'h0000_1000, 13'd0,    1'b1, '{STS_FULL,     12'd0, 32'd0}},
      '{ROW_CALL,  32'h0000_0002, 32'h0000_0000, 13'd0,    1'b0, '{STS_HEAD_HIT, 12'd0, 32'd0}},
      '{ROW_LIMIT, 32'h0000_0000, 32'h0000_0000, 13'd0,    1'b0, '{STS_HEAD_HIT, 12'd0, 32'd0}},
      '{ROW_CALL,  32'h0000_0004, 32'h1234_5678, 13'd0,    1'b1, '{STS_FULL,     12'd0, 32'd0}},
      '{ROW_CALL,  32'h0000_0006, 32'h0000_1000, 13'd0,    1'b0, '{STS_HEAD_HIT, 12'd0, 32'd0}},
      '{ROW_LIMIT, 32'h0000_0000, 32'h0000_0000, 13'd8191, 1'b0, '{STS_HEAD_HIT, 12'd0, 32'd0}},
      '{ROW_CALL,  32'h0000_0018, 32'hDEAD_BEEF, 13'd0,    1'b1, '{STS_NEW,      12'd6, 32'd1}},
      '{ROW_CALL,  32'h0000_0018, 32'h5555_AAAA, 13'd0,    1'b1, '{STS_NEW,      12'd7, 32'd1}},
      '{ROW_CALL,  32'h0000_0019, 32'hDEAD_BEEF, 13'd0,    1'b0, '{STS_HEAD_HIT, 12'd0, 32'd0}}
    };

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < NDIR; i++) begin
      if (dir_rows[i].kind == ROW_LIMIT)
        set_arc_limit(dir_rows[i].limit);
      else
        send_call(dir_rows[i].caller, dir_rows[i].callee, dir_rows[i].typed,
                  dir_rows[i].want);
    end

    for (int ph = 0; ph < NPHASE; ph++) begin
      lim = (ph == NEAR_FULL_PHASE) ? LIMIT_W'(next_free + 6) : PHASE_LIMIT[ph];
      set_arc_limit(lim);
      // fresh hot set per phase keeps chains short but deep enough to reorder
      for (int k = 0; k < NHOT_BUCKETS; k++) hot_bucket[k] = 12'($urandom_range(0, 4095));
      for (int k = 0; k < NHOT_CALLEES; k++) hot_callee[k] = $urandom;
      for (int n = 0; n < PHASE_CALLS; n++) begin
        r = $urandom_range(0, 99);
        if (r < 8) begin
          caller = $urandom;
          callee = $urandom;
        end else if (r < 14) begin
          caller = {17'd0, 12'($urandom_range(0, 4095)), 3'($urandom_range(0, 7))};
          callee = $urandom;
        end else begin
          caller = {17'd0, hot_bucket[$urandom_range(0, NHOT_BUCKETS - 1)],
                    3'($urandom_range(0, 7))};
          callee = (r < 84) ? hot_callee[$urandom_range(0, NHOT_CALLEES - 1)] : $urandom;
        end
        send_call(caller, callee, 1'b0, '0);
      end
    end

    release_input();
    while (pending_arcs.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("%0d calls over %0d arc limit writes (0, 1, near full, 4096, 8191 among them)",
             calls_sent, limit_writes);
    $display("head hits %0d, moved to front %0d, new arcs %0d, full drops %0d, range drops %0d",
             status_seen[STS_HEAD_HIT], status_seen[STS_MOVED], status_seen[STS_NEW],
             status_seen[STS_FULL], status_seen[STS_RANGE]);
    if (errors == 0) begin
      $display("call_arc_counter_table regression: pass");
    end else begin
      $display("call_arc_counter_table regression: fail");
    end
    $finish;
  end

endmodule

### files.f
hdl/cact_pkg.sv
hdl/cact_bucket_hash.sv
hdl/call_arc_counter_table.sv
tb/call_arc_counter_table_tb.sv
